// ----- design/mblt_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the MIDI binding learn table.
// No dependencies; used by mblt_ctrl, mblt_dp and midi_binding_learn_table.
package mblt_pkg;

  localparam int MAX_MAPPINGS = 64;
  localparam int IDX_W = (MAX_MAPPINGS > 1) ? $clog2(MAX_MAPPINGS) : 1;
  localparam int CNT_W = $clog2(MAX_MAPPINGS + 1);

  localparam int MODE_W = 3;
  localparam int IN_W   = 56;
  localparam int OUT_W  = 24;

  localparam logic [2:0] MODE_MIDI      = 3'd0;
  localparam logic [2:0] MODE_ADD       = 3'd1;
  localparam logic [2:0] MODE_REMOVE    = 3'd2;
  localparam logic [2:0] MODE_CLEAR     = 3'd3;
  localparam logic [2:0] MODE_LEARN_ON  = 3'd4;
  localparam logic [2:0] MODE_LEARN_OFF = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  localparam logic [3:0] KIND_CC      = 4'hB;
  localparam logic [3:0] KIND_NOTE_ON = 4'h9;

  typedef struct packed {
    logic [4:0] channel;
    logic [6:0] number;
    logic       is_cc;
    logic [3:0] action;
    logic [7:0] track;
    logic [7:0] scene;
  } entry_t;

  typedef enum logic [2:0] {
    OP_LOOKUP,
    OP_LEARN,
    OP_ADD,
    OP_REMOVE,
    OP_MISC
  } op_t;

  typedef struct packed {
    logic load_in;
    logic scan_start;
    logic append;
    logic apply_misc;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic scan_busy;
    logic out_busy;
  } stat_t;

endpackage

// ----- design/mblt_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer for the MIDI binding learn table: accepts a transaction, runs
// scan, append or misc steps, hands the result to the output register. Uses mblt_pkg.
module mblt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  mblt_pkg::stat_t stat,
  output mblt_pkg::cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_DISPATCH = 5'b00010,
    S_SCAN     = 5'b00100,
    S_APPEND   = 5'b01000,
    S_RESP     = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.op)
          mblt_pkg::OP_LOOKUP, mblt_pkg::OP_LEARN, mblt_pkg::OP_REMOVE: begin
            cmd.scan_start = 1'b1;
            state_next     = S_SCAN;
          end
          mblt_pkg::OP_ADD: begin
            state_next = S_APPEND;
          end
          default: begin
            cmd.apply_misc = 1'b1;
            state_next     = S_RESP;
          end
        endcase
      end
      S_SCAN: begin
        if (!stat.scan_busy) begin
          state_next = (stat.op == mblt_pkg::OP_LEARN) ? S_APPEND : S_RESP;
        end
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- design/mblt_dp.sv -----
`timescale 1ns / 1ps
// Datapath of the MIDI binding learn table: binding memory, scan and
// compaction pointers, learn registers, result and output registers. Uses mblt_pkg.
module mblt_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [mblt_pkg::IN_W-1:0]   in_data,
  input  logic [mblt_pkg::MODE_W-1:0] in_user,
  input  mblt_pkg::cmd_t              cmd,
  output mblt_pkg::stat_t             stat,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mblt_pkg::OUT_W-1:0]  out_data
);

  logic [2:0]       mode;
  logic [7:0]       sb;
  logic [6:0]       d1;
  logic [6:0]       d2;
  mblt_pkg::entry_t arg;

  logic       learn_armed;
  logic [3:0] learn_action;
  logic [7:0] learn_track;
  logic [7:0] learn_scene;

  logic [mblt_pkg::CNT_W-1:0] entry_count;
  logic [mblt_pkg::CNT_W-1:0] rd_ptr;
  logic [mblt_pkg::CNT_W-1:0] wr_ptr;
  logic                       rd_valid;
  logic                       scan_busy;

  mblt_pkg::entry_t           mem [mblt_pkg::MAX_MAPPINGS];
  mblt_pkg::entry_t           rd_data;
  logic                       mem_we;
  logic [mblt_pkg::IDX_W-1:0] mem_waddr;
  mblt_pkg::entry_t           mem_wdata;

  logic       res_handled, res_fire;
  logic [3:0] res_action;
  logic [7:0] res_track, res_scene;
  logic [1:0] res_status;

  logic       out_handled, out_fire;
  logic [3:0] out_action;
  logic [7:0] out_track, out_scene;
  logic [1:0] out_status;

  logic             msg_is_cc, msg_ok;
  logic [4:0]       msg_chan;
  mblt_pkg::op_t    op;
  mblt_pkg::entry_t app_entry;
  logic             table_full;
  logic             lookup_hit, bind_hit, target_hit, scan_hit, keep;
  logic             at_end;

  // decode of the captured MIDI message
  always_comb begin
    msg_is_cc = (sb[7:4] == mblt_pkg::KIND_CC);
    msg_ok    = msg_is_cc || ((sb[7:4] == mblt_pkg::KIND_NOTE_ON) && (d2 != 7'd0));
    msg_chan  = {1'b0, sb[3:0]} + 5'd1;
    case (mode)
      mblt_pkg::MODE_MIDI: begin
        if (!msg_ok) begin
          op = mblt_pkg::OP_MISC;
        end else if (learn_armed) begin
          op = mblt_pkg::OP_LEARN;
        end else begin
          op = mblt_pkg::OP_LOOKUP;
        end
      end
      mblt_pkg::MODE_ADD:    op = mblt_pkg::OP_ADD;
      mblt_pkg::MODE_REMOVE: op = mblt_pkg::OP_REMOVE;
      default:               op = mblt_pkg::OP_MISC;
    endcase
  end

  always_comb begin
    if (op == mblt_pkg::OP_LEARN) begin
      app_entry.channel = msg_chan;
      app_entry.number  = d1;
      app_entry.is_cc   = msg_is_cc;
      app_entry.action  = learn_action;
      app_entry.track   = learn_track;
      app_entry.scene   = learn_scene;
    end else begin
      app_entry = arg;
    end
  end

  assign table_full = (entry_count >= mblt_pkg::CNT_W'(mblt_pkg::MAX_MAPPINGS));
  assign at_end     = (rd_ptr == entry_count);

  assign lookup_hit = ((rd_data.channel == 5'd0) || (rd_data.channel == msg_chan)) &&
                      (rd_data.is_cc == msg_is_cc) && (rd_data.number == d1);
  assign bind_hit   = (rd_data.channel == msg_chan) && (rd_data.is_cc == msg_is_cc) &&
                      (rd_data.number == d1);
  assign target_hit = (rd_data.action == arg.action) && (rd_data.track == arg.track) &&
                      (rd_data.scene == arg.scene);

  always_comb begin
    case (op)
      mblt_pkg::OP_LOOKUP: scan_hit = lookup_hit;
      mblt_pkg::OP_LEARN:  scan_hit = bind_hit;
      default:             scan_hit = target_hit;
    endcase
  end

  // surviving entry during a compaction pass
  assign keep = scan_busy && rd_valid && (op != mblt_pkg::OP_LOOKUP) && !scan_hit;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_ptr[mblt_pkg::IDX_W-1:0];
    mem_wdata = rd_data;
    if (keep) begin
      mem_we = 1'b1;
    end else if (cmd.append && !table_full) begin
      mem_we    = 1'b1;
      mem_waddr = entry_count[mblt_pkg::IDX_W-1:0];
      mem_wdata = app_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_ptr[mblt_pkg::IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count  <= '0;
      learn_armed  <= 1'b0;
      learn_action <= '0;
      learn_track  <= '0;
      learn_scene  <= '0;
      scan_busy    <= 1'b0;
      rd_valid     <= 1'b0;
      rd_ptr       <= '0;
      wr_ptr       <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.load_in) begin
        mode        <= in_user;
        sb          <= in_data[7:0];
        d1          <= in_data[14:8];
        d2          <= in_data[21:15];
        arg.channel <= in_data[26:22];
        arg.number  <= in_data[33:27];
        arg.is_cc   <= in_data[34];
        arg.action  <= in_data[38:35];
        arg.track   <= in_data[46:39];
        arg.scene   <= in_data[54:47];
        res_handled <= 1'b0;
        res_fire    <= 1'b0;
        res_action  <= '0;
        res_track   <= '0;
        res_scene   <= '0;
        res_status  <= mblt_pkg::ST_OK;
      end

      if (cmd.scan_start) begin
        scan_busy  <= 1'b1;
        rd_ptr     <= '0;
        wr_ptr     <= '0;
        rd_valid   <= 1'b0;
        res_status <= (op == mblt_pkg::OP_LOOKUP) ? mblt_pkg::ST_IGNORED : mblt_pkg::ST_OK;
      end else if (scan_busy) begin
        if (rd_valid && (op == mblt_pkg::OP_LOOKUP) && lookup_hit) begin
          scan_busy   <= 1'b0;
          rd_valid    <= 1'b0;
          res_handled <= 1'b1;
          res_fire    <= 1'b1;
          res_action  <= rd_data.action;
          res_track   <= rd_data.track;
          res_scene   <= rd_data.scene;
          res_status  <= mblt_pkg::ST_OK;
        end else if (at_end && !rd_valid) begin
          scan_busy <= 1'b0;
          if (op != mblt_pkg::OP_LOOKUP) begin
            entry_count <= wr_ptr;
          end
        end else begin
          rd_valid <= !at_end;
          if (!at_end) begin
            rd_ptr <= rd_ptr + mblt_pkg::CNT_W'(1);
          end
          if (keep) begin
            wr_ptr <= wr_ptr + mblt_pkg::CNT_W'(1);
          end
        end
      end

      if (cmd.append) begin
        if (table_full) begin
          res_status <= mblt_pkg::ST_FULL;
        end else begin
          entry_count <= entry_count + mblt_pkg::CNT_W'(1);
          res_status  <= mblt_pkg::ST_OK;
        end
        if (op == mblt_pkg::OP_LEARN) begin
          res_handled <= 1'b1;
          learn_armed <= 1'b0;
        end
      end

      if (cmd.apply_misc) begin
        case (mode)
          mblt_pkg::MODE_CLEAR: begin
            entry_count <= '0;
          end
          mblt_pkg::MODE_LEARN_ON: begin
            learn_armed  <= 1'b1;
            learn_action <= arg.action;
            learn_track  <= arg.track;
            learn_scene  <= arg.scene;
          end
          mblt_pkg::MODE_LEARN_OFF: begin
            learn_armed <= 1'b0;
          end
          default: begin
            res_status <= mblt_pkg::ST_IGNORED;
          end
        endcase
      end

      if (cmd.load_out) begin
        out_valid   <= 1'b1;
        out_handled <= res_handled;
        out_fire    <= res_fire;
        out_action  <= res_action;
        out_track   <= res_track;
        out_scene   <= res_scene;
        out_status  <= res_status;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_data = {out_status, out_scene, out_track, out_action, out_fire, out_handled};

  assign stat.op        = op;
  assign stat.scan_busy = scan_busy;
  assign stat.out_busy  = out_valid && !out_ready;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    entry_count <= mblt_pkg::CNT_W'(mblt_pkg::MAX_MAPPINGS))
    else $error("entry count above table depth");

  a_compact_order: assert property (@(posedge clk) disable iff (rst)
    scan_busy |-> (wr_ptr <= rd_ptr))
    else $error("compaction write pointer passed read pointer");

  a_out_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result loaded over a pending result");

  a_learn_ends: assert property (@(posedge clk) disable iff (rst)
    (cmd.append && (op == mblt_pkg::OP_LEARN)) |=> !learn_armed)
    else $error("learn mode still armed after learned entry");

endmodule

// ----- design/midi_binding_learn_table.sv -----
`timescale 1ns / 1ps
// Top level of the MIDI binding learn table: stream ports, controller and
// datapath. Depends on mblt_pkg, mblt_ctrl and mblt_dp.
//
// One result transaction follows every input transaction. Clear, start learn,
// stop learn, unused modes and ignored MIDI messages go straight from dispatch
// to the result, and an add goes to its append without a scan. Other MIDI
// messages and removals scan the binding table one entry per cycle through its
// single read port. A lookup stops at the first matching entry; one with no
// match walks the whole table. A removal walks the whole table, and a learned
// message walks it too and then appends. A result waits while the output
// register holds one not yet taken. The table needs no clearing pass after
// reset. A new item is accepted as soon as the previous result sits in the
// output register.
module midi_binding_learn_table (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // [7:0] status_byte, [14:8] data_one, [21:15] data_two, [26:22] bind_channel,
  // [33:27] bind_number, [34] bind_is_cc, [38:35] action_code,
  // [46:39] track_index, [54:47] scene_index, [55] zero
  input  logic [mblt_pkg::IN_W-1:0]   s_axis_tdata,
  // [2:0] mode
  input  logic [mblt_pkg::MODE_W-1:0] s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [0] handled, [1] fire, [5:2] out_action, [13:6] out_track,
  // [21:14] out_scene, [23:22] status
  output logic [mblt_pkg::OUT_W-1:0]  m_axis_tdata
);

  mblt_pkg::cmd_t  cmd;
  mblt_pkg::stat_t stat;

  mblt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mblt_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

// ----- tb/midi_binding_learn_table_chk.sv -----
`timescale 1ns / 1ps
// Scoreboard for midi_binding_learn_table: mirrors the binding list and learn
// state from accepted commands and checks result transactions in order.
// Depends on mblt_pkg.
module midi_binding_learn_table_chk (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  input  logic                        s_axis_tready,
  input  logic [mblt_pkg::IN_W-1:0]   s_axis_tdata,
  input  logic [mblt_pkg::MODE_W-1:0] s_axis_tuser,
  input  logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  input  logic [mblt_pkg::OUT_W-1:0]  m_axis_tdata,
  output int                          errors,
  output int                          pending,
  output int                          fired,
  output int                          learned,
  output int                          dropped
);

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] scene;
    logic [7:0] track;
    logic [3:0] action;
    logic       fire;
    logic       handled;
  } reply_t;

  mblt_pkg::entry_t bindings [mblt_pkg::MAX_MAPPINGS];
  int               bind_cnt;
  logic             learn_armed;
  logic [3:0]       learn_action;
  logic [7:0]       learn_track;
  logic [7:0]       learn_scene;
  reply_t           due_replies [$];

  // keep entries that do not hit the key, in order
  task automatic drop_matching(input mblt_pkg::entry_t key, input logic by_binding);
    int  w;
    logic hit;
    w = 0;
    for (int r = 0; r < bind_cnt; r++) begin
      if (by_binding)
        hit = bindings[r].channel == key.channel && bindings[r].number == key.number &&
              bindings[r].is_cc == key.is_cc;
      else
        hit = bindings[r].action == key.action && bindings[r].track == key.track &&
              bindings[r].scene == key.scene;
      if (!hit) begin
        bindings[w] = bindings[r];
        w++;
      end
    end
    bind_cnt = w;
  endtask

  task automatic append_binding(input mblt_pkg::entry_t e, output logic [1:0] st);
    if (bind_cnt >= mblt_pkg::MAX_MAPPINGS) begin
      st = mblt_pkg::ST_FULL;
      dropped++;
    end else begin
      bindings[bind_cnt] = e;
      bind_cnt++;
      st = mblt_pkg::ST_OK;
    end
  endtask

  task automatic apply_command(input logic [2:0] m, input logic [mblt_pkg::IN_W-1:0] d,
                               output reply_t r);
    mblt_pkg::entry_t arg;
    mblt_pkg::entry_t msg;
    logic [7:0]       sb;
    logic             is_cc;
    logic             is_note;
    logic [1:0]       st;
    r = '0;
    msg = '0;
    sb = d[7:0];
    arg.channel = d[26:22];
    arg.number  = d[33:27];
    arg.is_cc   = d[34];
    arg.action  = d[38:35];
    arg.track   = d[46:39];
    arg.scene   = d[54:47];
    case (m)
      mblt_pkg::MODE_MIDI: begin
        is_cc   = sb[7:4] == mblt_pkg::KIND_CC;
        is_note = sb[7:4] == mblt_pkg::KIND_NOTE_ON && d[21:15] != 7'd0;
        if (!is_cc && !is_note) begin
          r.status = mblt_pkg::ST_IGNORED;
        end else begin
          msg.channel = {1'b0, sb[3:0]} + 5'd1;
          msg.number  = d[14:8];
          msg.is_cc   = is_cc;
          if (learn_armed) begin
            msg.action = learn_action;
            msg.track  = learn_track;
            msg.scene  = learn_scene;
            drop_matching(msg, 1'b1);
            append_binding(msg, st);
            r.status = st;
            r.handled = 1'b1;
            learn_armed = 1'b0;
            learned++;
          end else begin
            r.status = mblt_pkg::ST_IGNORED;
            for (int i = 0; i < bind_cnt && !r.fire; i++) begin
              if ((bindings[i].channel == 5'd0 || bindings[i].channel == msg.channel) &&
                  bindings[i].is_cc == msg.is_cc && bindings[i].number == msg.number) begin
                r.handled = 1'b1;
                r.fire    = 1'b1;
                r.action  = bindings[i].action;
                r.track   = bindings[i].track;
                r.scene   = bindings[i].scene;
                r.status  = mblt_pkg::ST_OK;
                fired++;
              end
            end
          end
        end
      end
      mblt_pkg::MODE_ADD: begin
        append_binding(arg, st);
        r.status = st;
      end
      mblt_pkg::MODE_REMOVE:    drop_matching(arg, 1'b0);
      mblt_pkg::MODE_CLEAR:     bind_cnt = 0;
      mblt_pkg::MODE_LEARN_ON: begin
        learn_armed  = 1'b1;
        learn_action = arg.action;
        learn_track  = arg.track;
        learn_scene  = arg.scene;
      end
      mblt_pkg::MODE_LEARN_OFF: learn_armed = 1'b0;
      default:                  r.status = mblt_pkg::ST_IGNORED;
    endcase
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    reply_t want;
    reply_t got;
    if (rst) begin
      bind_cnt = 0;
      learn_armed = 1'b0;
      learn_action = '0;
      learn_track = '0;
      learn_scene = '0;
      due_replies.delete();
      errors = 0;
      fired = 0;
      learned = 0;
      dropped = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        apply_command(s_axis_tuser, s_axis_tdata, want);
        due_replies.insert(due_replies.size(), want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (due_replies.size() == 0) begin
          $display("%0t: unexpected result transaction, expected none, actual %h",
                   $time, got);
          errors++;
        end else begin
          want = due_replies.pop_front();
          check_field("handled", int'(want.handled), int'(got.handled));
          check_field("fire", int'(want.fire), int'(got.fire));
          check_field("out_action", int'(want.action), int'(got.action));
          check_field("out_track", int'(want.track), int'(got.track));
          check_field("out_scene", int'(want.scene), int'(got.scene));
          check_field("status", int'(want.status), int'(got.status));
        end
      end
    end
    pending = due_replies.size();
  end

endmodule

// ----- tb/midi_binding_learn_table_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for midi_binding_learn_table: clock, reset, command stimulus,
// random idling on both streams and the verdict. Depends on mblt_pkg,
// midi_binding_learn_table and midi_binding_learn_table_chk.
module midi_binding_learn_table_tb;

  localparam logic [2:0] MODE_SPARE_6 = 3'd6;
  localparam logic [2:0] MODE_SPARE_7 = 3'd7;
  localparam int N_ITEMS     = 1150;
  localparam int STALL_LIMIT = 3000;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [mblt_pkg::IN_W-1:0]   s_axis_tdata = '0;
  logic [mblt_pkg::MODE_W-1:0] s_axis_tuser = '0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [mblt_pkg::OUT_W-1:0]  m_axis_tdata;

  int errors, pending, fired, learned, dropped;
  int sent;
  int fills;
  int stall_cycles;
  bit quiet;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  midi_binding_learn_table u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  midi_binding_learn_table_chk u_chk (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .errors       (errors),
    .pending      (pending),
    .fired        (fired),
    .learned      (learned),
    .dropped      (dropped)
  );

  always @(negedge clk) m_axis_tready <= quiet || $urandom_range(99) >= 30;

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("midi_binding_learn_table regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [mblt_pkg::IN_W-1:0] filler();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return {1'b0, raw[mblt_pkg::IN_W-2:0]};
  endfunction

  task automatic push_item(input logic [2:0] m, input logic [mblt_pkg::IN_W-1:0] d);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 30) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= m;
    s_axis_tdata  <= d;
    do @(posedge clk); while (!s_axis_tready);
    sent++;
    quiet = sent >= 400 && sent < 550;
  endtask

  task automatic send_midi(input logic [7:0] sb, input logic [6:0] d1, input logic [6:0] d2);
    logic [mblt_pkg::IN_W-1:0] d;
    d = filler();
    d[7:0]   = sb;
    d[14:8]  = d1;
    d[21:15] = d2;
    push_item(mblt_pkg::MODE_MIDI, d);
  endtask

  task automatic send_add(input logic [4:0] ch, input logic [6:0] num, input logic cc,
                          input logic [3:0] act, input logic [7:0] trk, input logic [7:0] scn);
    logic [mblt_pkg::IN_W-1:0] d;
    d = filler();
    d[26:22] = ch;
    d[33:27] = num;
    d[34]    = cc;
    d[38:35] = act;
    d[46:39] = trk;
    d[54:47] = scn;
    push_item(mblt_pkg::MODE_ADD, d);
  endtask

  task automatic send_target(input logic [2:0] m, input logic [3:0] act,
                             input logic [7:0] trk, input logic [7:0] scn);
    logic [mblt_pkg::IN_W-1:0] d;
    d = filler();
    d[38:35] = act;
    d[46:39] = trk;
    d[54:47] = scn;
    push_item(m, d);
  endtask

  // small pools so that lookups, duplicates and removals hit often
  function automatic logic [4:0] pick_chan();
    int r;
    r = $urandom_range(9);
    if (r < 7) return 5'($urandom_range(4));
    return r == 7 ? 5'd16 : 5'($urandom_range(31));
  endfunction

  function automatic logic [6:0] pick_num();
    return $urandom_range(9) < 8 ? 7'($urandom_range(5)) : 7'($urandom_range(127));
  endfunction

  function automatic logic [7:0] pick_byte();
    return $urandom_range(9) < 8 ? 8'($urandom_range(1)) : 8'($urandom_range(255));
  endfunction

  function automatic logic [3:0] pick_act();
    return $urandom_range(9) < 8 ? 4'($urandom_range(3)) : 4'($urandom_range(15));
  endfunction

  function automatic logic [7:0] pick_status();
    int r;
    logic [3:0] kind;
    logic [3:0] nib;
    r = $urandom_range(9);
    kind = r < 4 ? mblt_pkg::KIND_CC :
           (r < 8 ? mblt_pkg::KIND_NOTE_ON : 4'($urandom_range(15)));
    nib  = $urandom_range(3) < 3 ? 4'($urandom_range(3)) : 4'($urandom_range(15));
    return {kind, nib};
  endfunction

  function automatic logic [6:0] pick_vel();
    return $urandom_range(9) == 0 ? 7'd0 : 7'($urandom_range(127));
  endfunction

  initial begin
    int r;
    int n;
    sent = 0;
    fills = 0;
    quiet = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty list, spare modes, list extremes, learn path, removal, clear
    send_midi({mblt_pkg::KIND_CC, 4'h0}, 7'd5, 7'd64);
    push_item(MODE_SPARE_6, filler());
    push_item(MODE_SPARE_7, filler());
    send_add(5'd0, 7'd127, 1'b1, 4'd15, 8'hFF, 8'hFF);
    send_add(5'd16, 7'd0, 1'b0, 4'd0, 8'h00, 8'h00);
    send_add(5'd31, 7'd10, 1'b1, 4'd3, 8'h12, 8'h34);
    send_midi({mblt_pkg::KIND_CC, 4'hF}, 7'd127, 7'd127);
    send_midi({mblt_pkg::KIND_NOTE_ON, 4'hF}, 7'd0, 7'd1);
    send_midi({mblt_pkg::KIND_NOTE_ON, 4'hF}, 7'd0, 7'd0);
    send_midi(8'h80, 7'd0, 7'd64);
    send_midi({mblt_pkg::KIND_CC, 4'hA}, 7'd10, 7'd1);
    send_target(mblt_pkg::MODE_LEARN_ON, 4'd7, 8'h55, 8'hAA);
    send_midi(8'hF0, 7'd127, 7'd127);
    send_midi({mblt_pkg::KIND_CC, 4'h3}, 7'd127, 7'd0);
    send_midi({mblt_pkg::KIND_CC, 4'h3}, 7'd127, 7'd9);
    send_target(mblt_pkg::MODE_LEARN_ON, 4'd1, 8'h01, 8'h02);
    push_item(mblt_pkg::MODE_LEARN_OFF, filler());
    send_midi({mblt_pkg::KIND_NOTE_ON, 4'h1}, 7'd20, 7'd64);
    send_target(mblt_pkg::MODE_REMOVE, 4'd15, 8'hFF, 8'hFF);
    send_midi({mblt_pkg::KIND_CC, 4'h3}, 7'd127, 7'd9);
    push_item(mblt_pkg::MODE_CLEAR, filler());
    send_midi({mblt_pkg::KIND_CC, 4'h3}, 7'd127, 7'd9);

    while (sent < N_ITEMS) begin
      r = $urandom_range(99);
      if (r < 35) begin
        n = $urandom_range(4, 1);
        repeat (n) send_midi(pick_status(), pick_num(), pick_vel());
      end else if (r < 55) begin
        n = $urandom_range(3, 1);
        repeat (n) send_add(pick_chan(), pick_num(), 1'($urandom_range(1)), pick_act(),
                            pick_byte(), pick_byte());
      end else if (r < 67) begin
        send_target(mblt_pkg::MODE_LEARN_ON, pick_act(), pick_byte(), pick_byte());
        if ($urandom_range(3) == 0)
          send_midi(8'($urandom_range(255)), 7'($urandom), 7'($urandom));
        send_midi(pick_status(), pick_num(), pick_vel());
      end else if (r < 75) begin
        send_target(mblt_pkg::MODE_REMOVE, pick_act(), pick_byte(), pick_byte());
      end else if (r < 80) begin
        case ($urandom_range(3))
          0: push_item(mblt_pkg::MODE_CLEAR, filler());
          1: push_item(mblt_pkg::MODE_LEARN_OFF, filler());
          2: push_item(MODE_SPARE_6, filler());
          default: push_item(MODE_SPARE_7, filler());
        endcase
      end else if (r < 82 && fills < 2) begin
        // overfill with channels that never match, then learn into the full list
        fills++;
        repeat (mblt_pkg::MAX_MAPPINGS + 2)
          send_add(5'd17 + 5'($urandom_range(14)), 7'($urandom), 1'($urandom),
                   4'($urandom), 8'($urandom), 8'($urandom));
        send_target(mblt_pkg::MODE_LEARN_ON, 4'($urandom), 8'($urandom), 8'($urandom));
        send_midi({mblt_pkg::KIND_CC, 4'($urandom_range(15))}, 7'($urandom), 7'($urandom));
        repeat (2) send_midi(pick_status(), pick_num(), pick_vel());
        push_item(mblt_pkg::MODE_CLEAR, filler());
      end else begin
        send_midi(8'($urandom_range(255)), 7'($urandom), 7'($urandom));
      end
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b0;

    wait (pending == 0);
    repeat (mblt_pkg::MAX_MAPPINGS + 8) @(posedge clk);

    $display("%0d commands: %0d actions dispatched, %0d bindings learned, %0d appends dropped",
             sent, fired, learned, dropped);
    $display("covered empty, partial and overfilled lists with idle and stall on both streams");
    if (errors == 0 && pending == 0) begin
      $display("midi_binding_learn_table regression: pass");
    end else begin
      $display("midi_binding_learn_table regression: fail");
    end
    $finish;
  end

endmodule
